### rtl/lts_pkg.sv
// Shared types and constants for the light tracker servo step block.
// No dependencies; every other file imports this package.
package lts_pkg;

	localparam int SENSOR_COUNT = 4;
	localparam int SLOT_W       = 2;
	localparam int SAMPLE_W     = 8;
	localparam int CFG_W        = 8;
	localparam int DUTY_W       = 10;
	localparam int CNT_W        = 3;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	localparam logic [DUTY_W-1:0] DUTY_BASE = 10'h106;

	localparam logic [CFG_W-1:0] GAIN_RST     = 8'd20;
	localparam logic [CFG_W-1:0] DEADBAND_RST = 8'd10;
	localparam logic [CFG_W-1:0] LIMIT_RST    = 8'd229;

	// register word indexes (paddr[3:2])
	localparam logic [1:0] REG_GAIN     = 2'd0;
	localparam logic [1:0] REG_DEADBAND = 2'd1;
	localparam logic [1:0] REG_LIMIT    = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CALC = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_LOAD = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic calc;
		logic div_step;
		logic update;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic last_slot;
		logic exceed;
		logic div_last;
		logic out_free;
	} dp_status_t;

	typedef struct packed {
		logic [CFG_W-1:0] gain;
		logic [CFG_W-1:0] deadband;
		logic [CFG_W-1:0] limit;
	} cfg_t;

endpackage

### rtl/lts_if.sv
// Request channel interfaces: sensor sample in, servo result out.
// Depends on lts_pkg for field widths.
interface lts_sample_if;
	import lts_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] light_sample;
	modport source (output valid, output light_sample, input ready);
	modport sink   (input valid, input light_sample, output ready);
endinterface

interface lts_result_if;
	import lts_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] servo_duty;
	logic              moved;
	modport source (output valid, output servo_duty, output moved, input ready);
	modport sink   (input valid, input servo_duty, input moved, output ready);
endinterface

### rtl/light_tracker_servo_step.sv
// Light tracker servo step: four light samples per frame, one servo result per frame.
// Samples are taken one per cycle while idle; a frame's result follows its fourth sample
// through average/compare, the divider, update and load into the output register; a
// difference inside the deadband skips the divider and update. A result held at the
// output stalls the next in load.
// Reset (arst_n, async low): slot 0, position 0, duty 0, registers to 20/10/229.
module light_tracker_servo_step (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lts_pkg::ADDR_W-1:0]       paddr,
	input  logic [lts_pkg::DATA_W-1:0]       pwdata,
	output logic [lts_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	// request channels
	lts_sample_if.sink                       sample_ch,
	lts_result_if.source                     result_ch
);
	import lts_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;
	state_t     state;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	// Register file: byte address 4*i, writes land on the access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain     <= GAIN_RST;
			cfg_q.deadband <= DEADBAND_RST;
			cfg_q.limit    <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GAIN:     cfg_q.gain     <= pwdata[CFG_W-1:0];
				REG_DEADBAND: cfg_q.deadband <= pwdata[CFG_W-1:0];
				REG_LIMIT:    cfg_q.limit    <= pwdata[CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN:     prdata = DATA_W'(cfg_q.gain);
			REG_DEADBAND: prdata = DATA_W'(cfg_q.deadband);
			REG_LIMIT:    prdata = DATA_W'(cfg_q.limit);
			default:      prdata = '0;
		endcase
	end

	// Sequencer: idle takes samples; the fourth opens calc -> div -> update -> load, or calc -> load inside the deadband.
	lts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.status   (status),
		.cmd      (cmd),
		.state    (state)
	);

	// Datapath holds the slots, divider, position/duty and the output register,
	// so a finished result can wait while the next frame's samples come in.
	lts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.light_sample (sample_ch.light_sample),
		.status       (status),
		.out_valid    (result_ch.valid),
		.out_ready    (result_ch.ready),
		.servo_duty   (result_ch.servo_duty),
		.moved        (result_ch.moved)
	);

	// Samples are only taken while the sequencer is idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ch.valid && sample_ch.ready) |-> (state == ST_IDLE))
		else $error("sample accepted outside idle");

	// A new result only follows a load step.
	a_valid_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_ch.valid) |-> ($past(state) == ST_LOAD))
		else $error("result valid without load");

	// A moving frame always reports a duty built from the base plus an even offset.
	a_moved_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.moved) |->
		(!result_ch.servo_duty[0] && (result_ch.servo_duty >= DUTY_BASE)))
		else $error("moved result with malformed duty");

endmodule

### rtl/lts_ctrl.sv
// Frame sequencer: one-hot FSM issuing datapath commands.
// Depends on lts_pkg (state_t, dp_cmd_t, dp_status_t).
module lts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lts_pkg::dp_status_t status,
	output lts_pkg::dp_cmd_t    cmd,
	output lts_pkg::state_t     state
);
	import lts_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = in_valid && in_ready;
		cmd.calc     = (state_q == ST_CALC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.update   = (state_q == ST_UPD);
		cmd.load     = (state_q == ST_LOAD) && status.out_free;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.last_slot) state_n = ST_CALC;
			end
			ST_CALC: begin
				state_n = status.exceed ? ST_DIV : ST_LOAD;
			end
			ST_DIV: begin
				if (status.div_last) state_n = ST_UPD;
			end
			ST_UPD: begin
				state_n = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

### rtl/lts_dp.sv
// Datapath: sample slots, pair averages, restoring divider, position and duty.
// Depends on lts_pkg.
module lts_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lts_pkg::dp_cmd_t                 cmd,
	input  lts_pkg::cfg_t                    cfg,
	input  logic [lts_pkg::SAMPLE_W-1:0]     light_sample,
	output lts_pkg::dp_status_t              status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lts_pkg::DUTY_W-1:0]       servo_duty,
	output logic                             moved
);
	import lts_pkg::*;

	logic [SAMPLE_W-1:0] store_q [SENSOR_COUNT];
	logic [SLOT_W-1:0]   slot_q;

	logic [SAMPLE_W:0]   upper_sum, lower_sum;
	logic [SAMPLE_W-1:0] upper_c, lower_c, diff_c, divisor_c;
	logic                up_c, exceed_c;

	logic [SAMPLE_W-1:0] quot_q, rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                up_q, moved_q;
	logic [SAMPLE_W:0]   shifted, divisor_x;
	logic                ge;

	logic [SAMPLE_W-1:0] pos_q, pos_n;
	logic [SAMPLE_W:0]   pos_sum;
	logic [DUTY_W-1:0]   duty_q;

	logic                out_valid_q, moved_out_q;
	logic [DUTY_W-1:0]   duty_out_q;

	// slot store: written on accept, no reset
	always_ff @(posedge clk) begin
		if (cmd.accept) store_q[slot_q] <= light_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.accept) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	// pair means and deadband check
	always_comb begin
		upper_sum = {1'b0, store_q[0]} + {1'b0, store_q[3]};
		lower_sum = {1'b0, store_q[1]} + {1'b0, store_q[2]};
		upper_c   = upper_sum[SAMPLE_W:1];
		lower_c   = lower_sum[SAMPLE_W:1];
		up_c      = upper_c < lower_c;
		diff_c    = up_c ? (lower_c - upper_c) : (upper_c - lower_c);
		exceed_c  = diff_c > cfg.deadband;
		divisor_c = (cfg.gain == '0) ? SAMPLE_W'(1) : cfg.gain;
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		shifted   = {rem_q, quot_q[SAMPLE_W-1]};
		divisor_x = {1'b0, divisor_c};
		ge        = shifted >= divisor_x;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			quot_q  <= diff_c;
			rem_q   <= '0;
			cnt_q   <= '0;
			up_q    <= up_c;
			moved_q <= exceed_c;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? SAMPLE_W'(shifted - divisor_x) : shifted[SAMPLE_W-1:0];
			quot_q <= {quot_q[SAMPLE_W-2:0], ge};
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	// position step, bounded both ways
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, quot_q};
		pos_n   = pos_q;
		if (up_q) begin
			if (pos_sum < {1'b0, cfg.limit}) pos_n = pos_sum[SAMPLE_W-1:0];
		end else begin
			if (pos_q > quot_q) pos_n = pos_q - quot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			duty_q <= '0;
		end else if (cmd.update) begin
			pos_q  <= pos_n;
			duty_q <= DUTY_BASE + {1'b0, pos_n, 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			duty_out_q  <= duty_q;
			moved_out_q <= moved_q;
		end
	end

	always_comb begin
		status           = '0;
		status.last_slot = (slot_q == SLOT_W'(SENSOR_COUNT - 1));
		status.exceed    = exceed_c;
		status.div_last  = (cnt_q == CNT_W'(SAMPLE_W - 1));
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign servo_duty = duty_out_q;
	assign moved      = moved_out_q;

endmodule

### sim/testbench.sv
// Testbench for light_tracker_servo_step: sample requests in, servo results out, APB config.
// Needs rtl/lts_pkg.sv, rtl/lts_if.sv, rtl/lts_ctrl.sv, rtl/lts_dp.sv and the top level.
`timescale 1ns / 100ps

module testbench;
	import lts_pkg::*;

	localparam int SETTLE = 24;     // cycles after the last result
	localparam int FRAMES = 38;     // frames per random phase
	localparam int HOLD   = 400;    // long receiver hold-off, in cycles

	// one servo result as the block reports it
	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              moved;
	} servo_out_t;

	// directed row: a sample and, on frame-closing rows, an optional hand-written result
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                typed;
		servo_out_t          result;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	lts_sample_if sample_bus();
	lts_result_if result_bus();

	light_tracker_servo_step i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample_ch (sample_bus),
		.result_ch (result_bus)
	);

	// tracker state as the testbench sees it
	logic [SAMPLE_W-1:0] samples_held [SENSOR_COUNT];
	logic [SLOT_W-1:0]   next_slot;
	logic [CFG_W-1:0]    track_pos;
	logic [DUTY_W-1:0]   track_duty;
	logic [CFG_W-1:0]    gain_cfg, dband_cfg, limit_cfg;

	servo_out_t          pending_results [$];
	logic [SAMPLE_W-1:0] frame_buf [SENSOR_COUNT];
	directed_row_t       plan [28];

	int  mismatches = 0;
	int  burst_left = 0;
	int  rand_sent  = 0;
	logic hold_off;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic log_mismatch(input string what);
		if (mismatches < 200)
			$display("%0t MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Advance the tracker by one sample. Returns 1 when the sample closes a frame,
	// with the servo result in res.
	function automatic logic track_sample(input logic [SAMPLE_W-1:0] s, output servo_out_t res);
		logic [SAMPLE_W:0]   up_sum, lo_sum, raised;
		logic [SAMPLE_W-1:0] upper, lower, diff, stp, div;
		logic                moved;
		samples_held[next_slot] = s;
		res = '0;
		if (int'(next_slot) != SENSOR_COUNT - 1) begin
			next_slot = next_slot + SLOT_W'(1);
			return 1'b0;
		end
		next_slot = '0;
		// pair means, floored half of a 9-bit sum
		up_sum = {1'b0, samples_held[0]} + {1'b0, samples_held[3]};
		lo_sum = {1'b0, samples_held[1]} + {1'b0, samples_held[2]};
		upper  = up_sum[SAMPLE_W:1];
		lower  = lo_sum[SAMPLE_W:1];
		diff   = (upper > lower) ? upper - lower : lower - upper;
		moved  = 1'b0;
		if (diff > dband_cfg) begin
			moved = 1'b1;
			div   = (gain_cfg == '0) ? 8'd1 : gain_cfg;   // zero divisor acts as one
			stp   = diff / div;
			if (upper < lower) begin
				raised = {1'b0, track_pos} + {1'b0, stp};
				if (raised < {1'b0, limit_cfg})
					track_pos = raised[CFG_W-1:0];
			end else if (track_pos > stp) begin
				track_pos = track_pos - stp;
			end
			// duty is rewritten even when the step was blocked
			track_duty = DUTY_BASE + {1'b0, track_pos, 1'b0};
		end
		res.duty  = track_duty;
		res.moved = moved;
		return 1'b1;
	endfunction

	// Offer one sample request; bursts of random length with random gaps in between.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
			input servo_out_t typed_out);
		servo_out_t predicted;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				sample_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_bus.valid        <= 1'b1;
		sample_bus.light_sample <= s;
		do @(posedge clk); while (!sample_bus.ready);
		if (track_sample(s, predicted))
			pending_results.push_back(typed ? typed_out : predicted);
	endtask

	// APB write, then read back the same register
	task automatic set_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(DATA_W-CFG_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GAIN:     gain_cfg  = v;
			REG_DEADBAND: dband_cfg = v;
			REG_LIMIT:    limit_cfg = v;
			default:      ;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== v)
			log_mismatch($sformatf("reg %0d reads %0h, wrote %0h", idx, prdata[CFG_W-1:0], v));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_phase(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] d,
			input logic [CFG_W-1:0] l);
		set_reg(REG_GAIN, g);
		set_reg(REG_DEADBAND, d);
		set_reg(REG_LIMIT, l);
	endtask

	function automatic logic [SAMPLE_W-1:0] clip8(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[SAMPLE_W-1:0];
	endfunction

	// Fill one frame of four samples, slot order 0..3 (0,3 upper pair; 1,2 lower pair).
	task automatic build_frame();
		int pick, base, off, hi, lo;
		pick = $urandom_range(0, 9);
		if (pick <= 3) begin
			foreach (frame_buf[k]) frame_buf[k] = SAMPLE_W'($urandom_range(0, 255));
		end else if (pick <= 6) begin
			// pair means that straddle the deadband edge
			base = $urandom_range(0, 255);
			off  = int'(dband_cfg) + int'($urandom_range(0, 3)) - 1;
			if ($urandom_range(0, 1)) off = -off;
			frame_buf[0] = clip8(base);
			frame_buf[3] = clip8(base + int'($urandom_range(0, 1)));
			frame_buf[1] = clip8(base + off);
			frame_buf[2] = clip8(base + off + int'($urandom_range(0, 1)));
		end else if (pick <= 8) begin
			// strong push one way, drives the position into its bounds
			hi = $urandom_range(200, 255);
			lo = $urandom_range(0, 55);
			if ($urandom_range(0, 1)) begin
				frame_buf[0] = SAMPLE_W'(lo);
				frame_buf[3] = SAMPLE_W'(lo + int'($urandom_range(0, 3)));
				frame_buf[1] = SAMPLE_W'(hi);
				frame_buf[2] = SAMPLE_W'(hi - int'($urandom_range(0, 3)));
			end else begin
				frame_buf[0] = SAMPLE_W'(hi);
				frame_buf[3] = SAMPLE_W'(hi - int'($urandom_range(0, 3)));
				frame_buf[1] = SAMPLE_W'(lo);
				frame_buf[2] = SAMPLE_W'(lo + int'($urandom_range(0, 3)));
			end
		end else begin
			foreach (frame_buf[k]) frame_buf[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
	endtask

	// Wait for every pending result, then let the block settle before touching registers
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int frames);
		for (int f = 0; f < frames; f++) begin
			build_frame();
			for (int k = 0; k < SENSOR_COUNT; k++) begin
				offer_sample(frame_buf[k], 1'b0, '0);
				rand_sent++;
			end
		end
		sample_bus.valid <= 1'b0;
		burst_left = 0;
		drain();
	endtask

	// Result receiver: stalls on a pattern that switches among always-ready,
	// coin-flip and one-in-five, plus the long hold-off below.
	initial begin
		int mode, left, tick;
		mode = 0;
		left = 0;
		tick = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 150);
			end
			left--;
			tick++;
			case (mode)
				0:       result_bus.ready <= !hold_off;
				1:       result_bus.ready <= !hold_off && ($urandom_range(0, 1) == 1);
				default: result_bus.ready <= !hold_off && (tick % 5 == 0);
			endcase
		end
	end

	// Long hold-off once random requests flow: the block fills and stalls its input
	initial begin
		hold_off = 1'b0;
		wait (rand_sent >= 120);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Result checker: every accepted result against the oldest prediction
	initial begin
		servo_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pending_results.size() == 0) begin
					log_mismatch($sformatf("unexpected result duty=%0d moved=%0b",
						result_bus.servo_duty, result_bus.moved));
				end else begin
					want = pending_results.pop_front();
					if (result_bus.servo_duty !== want.duty)
						log_mismatch($sformatf("servo_duty %0d, want %0d",
							result_bus.servo_duty, want.duty));
					if (result_bus.moved !== want.moved)
						log_mismatch($sformatf("moved %0b, want %0b",
							result_bus.moved, want.moved));
				end
			end
		end
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	// Main sequence: reset, directed frames, then random phases over several settings
	initial begin
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		sample_bus.valid        = 1'b0;
		sample_bus.light_sample = '0;
		foreach (samples_held[k]) samples_held[k] = '0;
		next_slot  = '0;
		track_pos  = '0;
		track_duty = '0;
		gain_cfg   = GAIN_RST;
		dband_cfg  = DEADBAND_RST;
		limit_cfg  = LIMIT_RST;

		// Directed frames under reset settings (gain 20, deadband 10, limit 229).
		// Hand-written results only where obvious.
		plan = '{
			// level light, nothing moved yet: duty still zero
			'{8'd100, 1'b0, '{10'd0, 1'b0}}, '{8'd100, 1'b0, '{10'd0, 1'b0}},
			'{8'd100, 1'b0, '{10'd0, 1'b0}}, '{8'd100, 1'b1, '{10'd0, 1'b0}},
			// full-scale up: step 255/20 = 12, duty 262 + 24
			'{8'd0,   1'b0, '{10'd0, 1'b0}}, '{8'd255, 1'b0, '{10'd0, 1'b0}},
			'{8'd255, 1'b0, '{10'd0, 1'b0}}, '{8'd0,   1'b1, '{10'd286, 1'b1}},
			// full-scale down blocked: position 12 not above step 12
			'{8'd255, 1'b0, '{10'd0, 1'b0}}, '{8'd0,   1'b0, '{10'd0, 1'b0}},
			'{8'd0,   1'b0, '{10'd0, 1'b0}}, '{8'd255, 1'b1, '{10'd286, 1'b1}},
			// up again, then a down step that is taken
			'{8'd0,   1'b0, '{10'd0, 1'b0}}, '{8'd255, 1'b0, '{10'd0, 1'b0}},
			'{8'd255, 1'b0, '{10'd0, 1'b0}}, '{8'd0,   1'b0, '{10'd0, 1'b0}},
			'{8'd255, 1'b0, '{10'd0, 1'b0}}, '{8'd0,   1'b0, '{10'd0, 1'b0}},
			'{8'd0,   1'b0, '{10'd0, 1'b0}}, '{8'd255, 1'b0, '{10'd0, 1'b0}},
			// difference equal to deadband: no move
			'{8'd100, 1'b0, '{10'd0, 1'b0}}, '{8'd110, 1'b0, '{10'd0, 1'b0}},
			'{8'd110, 1'b0, '{10'd0, 1'b0}}, '{8'd100, 1'b0, '{10'd0, 1'b0}},
			// odd pair sums, floored means
			'{8'd101, 1'b0, '{10'd0, 1'b0}}, '{8'd122, 1'b0, '{10'd0, 1'b0}},
			'{8'd1,   1'b0, '{10'd0, 1'b0}}, '{8'd100, 1'b0, '{10'd0, 1'b0}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer_sample(plan[i].sample, plan[i].typed, plan[i].result);
		sample_bus.valid <= 1'b0;
		burst_left = 0;
		drain();

		// extremes first, then zero divisor, an up-blocking limit, then random settings
		set_phase(8'd1, 8'd0, 8'd255);     run_phase(FRAMES);
		set_phase(8'd255, 8'd255, 8'd1);   run_phase(FRAMES);
		set_phase(8'd0, 8'd3, 8'd60);      run_phase(FRAMES);
		set_phase(8'd2, 8'd0, 8'd1);       run_phase(FRAMES);
		for (int p = 0; p < 4; p++) begin
			set_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 40)),
				CFG_W'($urandom_range(1, 255)));
			run_phase(FRAMES);
		end

		if (pending_results.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
